// ===== rtl/core/uart8_pkg.sv =====
// Shared types and constants for the 8N1 UART transceiver core.
// No dependencies; uart8_tx, uart8_rx and the core module import this package.
package uart8_pkg;

	// Serial line levels
	localparam logic LINE_IDLE  = 1'b1;
	localparam logic LINE_START = 1'b0;

	// Bit period register
	localparam logic [15:0] PERIOD_RESET = 16'd104;
	localparam logic [15:0] PERIOD_MIN   = 16'd2;

	// Frame position of the transmitter and the receiver
	typedef enum logic [1:0] {
		PH_IDLE,
		PH_START,
		PH_DATA,
		PH_STOP
	} phase_t;

	// One input item: one tick
	typedef struct packed {
		logic       rx_level;
		logic       tx_start;
		logic [7:0] tx_data;
	} item_t;

	// One result item: line and status for one tick
	typedef struct packed {
		logic       tx_level;
		logic       tx_busy;
		logic       rx_valid;
		logic [7:0] rx_data;
	} result_t;

	// Transmitter status for one tick
	typedef struct packed {
		logic level;
		logic busy;
	} tx_out_t;

	// Receiver status for one tick
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} rx_out_t;

endpackage

// ===== rtl/core/uart8_chan_if.sv =====
// Valid/ready channel interface used for items, results and configuration.
// The payload type is a parameter; no package dependency.
interface uart8_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/uart8_tx.sv =====
// Transmit side of the 8N1 UART: start bit, data bits LSB first, stop bit.
// Depends on uart8_pkg.
module uart8_tx #(
	parameter int DATA_BITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [15:0]       period,
	input  logic              start,
	input  logic [7:0]        data,
	output uart8_pkg::tx_out_t res
);
	import uart8_pkg::*;

	localparam int BIT_W = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;
	localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(DATA_BITS - 1);

	phase_t                 phase_q, phase_d, eff_phase;
	logic [DATA_BITS-1:0]   shift_q, shift_d, eff_shift;
	logic [15:0]            timer_q, timer_d, eff_timer, timer_inc;
	logic [BIT_W-1:0]       bit_q, bit_d, eff_bit;
	logic [DATA_BITS+7:0]   data_pad;
	logic                   bit_done;

	// A request while idle starts the frame on this very tick
	assign data_pad = {{DATA_BITS{1'b0}}, data};

	always_comb begin
		if (phase_q == PH_IDLE && start) begin
			eff_phase = PH_START;
			eff_shift = data_pad[DATA_BITS-1:0];
			eff_timer = '0;
			eff_bit   = '0;
		end else begin
			eff_phase = phase_q;
			eff_shift = shift_q;
			eff_timer = timer_q;
			eff_bit   = bit_q;
		end
	end

	assign timer_inc = eff_timer + 16'd1;
	assign bit_done  = (timer_inc >= period);

	// Next state
	always_comb begin
		phase_d = eff_phase;
		shift_d = eff_shift;
		timer_d = eff_timer;
		bit_d   = eff_bit;
		if (eff_phase != PH_IDLE) begin
			timer_d = bit_done ? 16'd0 : timer_inc;
			if (bit_done) begin
				case (eff_phase)
					PH_START: begin
						phase_d = PH_DATA;
						bit_d   = '0;
					end
					PH_DATA: begin
						shift_d = {1'b0, eff_shift[DATA_BITS-1:1]};
						if (eff_bit == LAST_BIT) begin
							phase_d = PH_STOP;
						end else begin
							bit_d = eff_bit + BIT_W'(1);
						end
					end
					PH_STOP: phase_d = PH_IDLE;
					default: phase_d = PH_IDLE;
				endcase
			end
		end
	end

	// Line level and busy flag for this tick
	always_comb begin
		res.busy = (eff_phase != PH_IDLE);
		case (eff_phase)
			PH_START: res.level = LINE_START;
			PH_DATA:  res.level = eff_shift[0];
			default:  res.level = LINE_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			shift_q <= '0;
			timer_q <= '0;
			bit_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			shift_q <= shift_d;
			timer_q <= timer_d;
			bit_q   <= bit_d;
		end
	end

endmodule

// ===== rtl/core/uart8_rx.sv =====
// Receive side of the 8N1 UART: start detect, mid-bit sampling, report at
// the middle of the stop bit. Depends on uart8_pkg.
module uart8_rx #(
	parameter int DATA_BITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [15:0]       period,
	input  logic [15:0]       half,
	input  logic              rx_level,
	output uart8_pkg::rx_out_t res
);
	import uart8_pkg::*;

	localparam int BIT_W = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;
	localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(DATA_BITS - 1);

	phase_t                 phase_q, phase_d;
	logic [DATA_BITS-1:0]   shift_q, shift_d;
	logic [15:0]            timer_q, timer_d, timer_inc, limit;
	logic [BIT_W-1:0]       bit_q, bit_d;
	logic [7:0]             hold_q, hold_d;
	logic [DATA_BITS+7:0]   shift_pad;
	logic                   bit_done;

	// Start bit runs half a period so later samples land mid-bit
	assign limit     = (phase_q == PH_START) ? half : period;
	assign timer_inc = timer_q + 16'd1;
	assign bit_done  = (timer_inc >= limit);
	assign shift_pad = {8'd0, shift_q};

	// Next state
	always_comb begin
		phase_d = phase_q;
		shift_d = shift_q;
		timer_d = timer_q;
		bit_d   = bit_q;
		case (phase_q)
			PH_IDLE: begin
				if (rx_level == LINE_START) begin
					phase_d = PH_START;
					shift_d = '0;
					timer_d = '0;
				end
			end
			PH_START: begin
				timer_d = bit_done ? 16'd0 : timer_inc;
				if (bit_done) begin
					phase_d = PH_DATA;
					bit_d   = '0;
				end
			end
			PH_DATA: begin
				timer_d = bit_done ? 16'd0 : timer_inc;
				if (bit_done) begin
					shift_d[bit_q] = rx_level;
					if (bit_q == LAST_BIT) begin
						phase_d = PH_STOP;
					end else begin
						bit_d = bit_q + BIT_W'(1);
					end
				end
			end
			PH_STOP: begin
				timer_d = bit_done ? 16'd0 : timer_inc;
				if (bit_done) begin
					phase_d = PH_IDLE;
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	// Byte report at the middle of the stop bit
	always_comb begin
		res.valid = (phase_q == PH_STOP) && bit_done;
		hold_d    = res.valid ? shift_pad[7:0] : hold_q;
		res.data  = hold_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			shift_q <= '0;
			timer_q <= '0;
			bit_q   <= '0;
			hold_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			shift_q <= shift_d;
			timer_q <= timer_d;
			bit_q   <= bit_d;
			hold_q  <= hold_d;
		end
	end

endmodule

// ===== rtl/core/uart_8n1_transceiver_core.sv =====
// Pipeline: an item is held in the input register, its result in the result
// register. Throughput: one item per cycle while results are taken; each tick
// is one pass through the bit timer increment and compare of tx and rx.
// Reset: arst_n clears both sides to idle, received byte to 0 and the bit
// period to 104; pipeline and result registers come up empty.
// Depends on uart8_pkg, uart8_chan_if, uart8_tx and uart8_rx.
module uart_8n1_transceiver_core #(
	parameter int DATA_BITS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	uart8_chan_if.sink   items,
	uart8_chan_if.source results,
	uart8_chan_if.sink   cfg
);
	import uart8_pkg::*;

	logic [15:0] period_q, period_eff, half_eff;
	item_t       item_s1;
	logic        valid_s1;
	result_t     result_s2;
	logic        valid_s2;
	logic        advance;
	tx_out_t     tx_res;
	rx_out_t     rx_res;

	// Configuration register, always ready
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (cfg.valid) begin
			period_q <= cfg.data;
		end
	end

	// Periods below two act as two
	assign period_eff = (period_q < PERIOD_MIN) ? PERIOD_MIN : period_q;
	assign half_eff   = {1'b0, period_eff[15:1]};

	// Input register; an item moves on when the result register frees up
	assign advance     = valid_s1 && (!valid_s2 || results.ready);
	assign items.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.ready && items.valid) begin
			item_s1 <= items.data;
		end
	end

	uart8_tx #(.DATA_BITS(DATA_BITS)) u_tx (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.period (period_eff),
		.start  (item_s1.tx_start),
		.data   (item_s1.tx_data),
		.res    (tx_res)
	);

	uart8_rx #(.DATA_BITS(DATA_BITS)) u_rx (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.period   (period_eff),
		.half     (half_eff),
		.rx_level (item_s1.rx_level),
		.res      (rx_res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (results.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2.tx_level <= tx_res.level;
			result_s2.tx_busy  <= tx_res.busy;
			result_s2.rx_valid <= rx_res.valid;
			result_s2.rx_data  <= rx_res.data;
		end
	end

	assign results.valid = valid_s2;
	assign results.data  = result_s2;

`ifndef SYNTHESIS
	// A tick that leaves the input register always lands in the result register
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("result register empty after advance");

	// A blocked item stays in the input register unchanged
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input register lost a stalled item");

	// The line is idle high whenever the transmitter is not busy
	a_idle_high: assert property (@(posedge clk) disable iff (!arst_n)
		!tx_res.busy |-> tx_res.level == LINE_IDLE)
		else $error("transmit line low while not busy");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for uart_8n1_transceiver_core: drives one tick item per
// handshake, predicts every status item in step and compares field by field.
// Depends on uart8_pkg, uart8_chan_if and the core RTL.
module tb_top;
	import uart8_pkg::*;

	localparam int BYTE_BITS = 8;
	localparam int LIMIT     = 200000;

	logic clk = 1'b0;
	logic arst_n;

	uart8_chan_if #(.T(item_t))       items_if ();
	uart8_chan_if #(.T(result_t))     results_if ();
	uart8_chan_if #(.T(logic [15:0])) cfg_if ();

	uart_8n1_transceiver_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_if),
		.results (results_if),
		.cfg     (cfg_if)
	);

	always #4 clk = ~clk;

	// Ticks waiting to be sent and status items still owed by the core
	item_t   pending_ticks[$];
	result_t due_status[$];
	int      errors;
	int      ticks_queued;
	int      tx_odds = 5;
	bit      steady;
	int      cycles;

	// Mirror of the core's line state
	logic [15:0] period = PERIOD_RESET;
	phase_t      tx_ph  = PH_IDLE;
	int          tx_bit;
	int          tx_tmr;
	logic [7:0]  tx_sh  = '0;
	phase_t      rx_ph  = PH_IDLE;
	int          rx_bit;
	int          rx_tmr;
	logic [7:0]  rx_sh  = '0;
	logic [7:0]  rx_hold = '0;

	// Periods below the minimum run as the minimum
	function automatic int line_ticks();
		return int'((period < PERIOD_MIN) ? PERIOD_MIN : period);
	endfunction

	// One tick of transmitter and receiver; returns the line status
	function automatic result_t advance_uart(item_t it);
		int      p;
		result_t r;
		p = line_ticks();
		r.tx_level = LINE_IDLE;
		r.tx_busy  = 1'b0;
		r.rx_valid = 1'b0;

		// transmitter: a request while busy is dropped
		if (tx_ph == PH_IDLE && it.tx_start) begin
			tx_ph  = PH_START;
			tx_sh  = it.tx_data;
			tx_tmr = 0;
			tx_bit = 0;
		end
		if (tx_ph != PH_IDLE) begin
			r.tx_busy = 1'b1;
			case (tx_ph)
				PH_START: r.tx_level = LINE_START;
				PH_DATA:  r.tx_level = tx_sh[0];
				default:  r.tx_level = LINE_IDLE;
			endcase
			tx_tmr++;
			if (tx_tmr >= p) begin
				tx_tmr = 0;
				case (tx_ph)
					PH_START: begin
						tx_ph  = PH_DATA;
						tx_bit = 0;
					end
					PH_DATA: begin
						tx_sh = tx_sh >> 1;
						if (tx_bit == BYTE_BITS - 1)
							tx_ph = PH_STOP;
						else
							tx_bit++;
					end
					default: tx_ph = PH_IDLE;
				endcase
			end
		end

		// receiver: half a bit into the start bit, then one bit per sample
		case (rx_ph)
			PH_IDLE: begin
				if (it.rx_level == LINE_START) begin
					rx_ph  = PH_START;
					rx_sh  = '0;
					rx_tmr = 0;
				end
			end
			PH_START: begin
				rx_tmr++;
				if (rx_tmr >= p / 2) begin
					rx_tmr = 0;
					rx_ph  = PH_DATA;
					rx_bit = 0;
				end
			end
			PH_DATA: begin
				rx_tmr++;
				if (rx_tmr >= p) begin
					rx_tmr = 0;
					rx_sh[rx_bit] = it.rx_level;
					if (rx_bit == BYTE_BITS - 1)
						rx_ph = PH_STOP;
					else
						rx_bit++;
				end
			end
			default: begin
				rx_tmr++;
				if (rx_tmr >= p) begin
					rx_tmr     = 0;
					rx_hold    = rx_sh;
					r.rx_valid = 1'b1;
					rx_ph      = PH_IDLE;
				end
			end
		endcase
		r.rx_data = rx_hold;
		return r;
	endfunction

	// Sender: presents queued ticks with a random gap after each item unless steady
	int send_wait;
	always @(posedge clk) begin
		if (!arst_n) begin
			items_if.valid <= 1'b0;
			send_wait = 0;
		end else begin
			if (items_if.valid && items_if.ready) begin
				due_status.push_back(advance_uart(items_if.data));
				send_wait = steady ? 0 : $urandom_range(0, 4);
			end
			if (!items_if.valid || items_if.ready) begin
				if (send_wait > 0) begin
					items_if.valid <= 1'b0;
					send_wait--;
				end else if (pending_ticks.size() != 0) begin
					items_if.valid <= 1'b1;
					items_if.data  <= pending_ticks.pop_front();
				end else begin
					items_if.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver side: checks each status item, stalls at random after it unless steady
	int recv_wait;
	always @(posedge clk) begin
		if (!arst_n) begin
			results_if.ready <= 1'b0;
			recv_wait = 0;
		end else begin
			if (results_if.valid && results_if.ready) begin
				if (due_status.size() == 0) begin
					$error("status item with nothing outstanding");
					errors++;
				end else begin
					result_t want;
					want = due_status.pop_front();
					if (results_if.data.tx_level !== want.tx_level) begin
						$error("tx_level: expected %0d, got %0d",
							want.tx_level, results_if.data.tx_level);
						errors++;
					end
					if (results_if.data.tx_busy !== want.tx_busy) begin
						$error("tx_busy: expected %0d, got %0d",
							want.tx_busy, results_if.data.tx_busy);
						errors++;
					end
					if (results_if.data.rx_valid !== want.rx_valid) begin
						$error("rx_valid: expected %0d, got %0d",
							want.rx_valid, results_if.data.rx_valid);
						errors++;
					end
					if (results_if.data.rx_data !== want.rx_data) begin
						$error("rx_data: expected %0h, got %0h",
							want.rx_data, results_if.data.rx_data);
						errors++;
					end
				end
				recv_wait = steady ? 0 : $urandom_range(0, 4);
			end
			if (recv_wait > 0) begin
				results_if.ready <= 1'b0;
				recv_wait--;
			end else begin
				results_if.ready <= 1'b1;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Idle: nothing queued, nothing offered, nothing owed
	task automatic wait_idle();
		while (pending_ticks.size() != 0 || items_if.valid || due_status.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_period(input logic [15:0] v);
		wait_idle();
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= v;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		period = v;
		@(negedge clk);
	endtask

	task automatic push_item(input logic rx, input logic start, input logic [7:0] data);
		item_t t;
		t.rx_level = rx;
		t.tx_start = start;
		t.tx_data  = data;
		pending_ticks.push_back(t);
		ticks_queued++;
	endtask

	// One tick on the receive line with a random transmit request
	task automatic push_tick(input logic rx);
		push_item(rx, $urandom_range(0, tx_odds) == 0, 8'($urandom));
	endtask

	// First nbits bits of a frame on the receive line: start, data, stop
	task automatic push_frame(input logic [7:0] b, input bit stop_low, input int nbits);
		logic lvl;
		for (int k = 0; k < nbits; k++) begin
			if (k == 0)
				lvl = LINE_START;
			else if (k == BYTE_BITS + 1)
				lvl = stop_low ? LINE_START : LINE_IDLE;
			else
				lvl = b[k-1];
			repeat (line_ticks()) push_tick(lvl);
		end
	endtask

	initial begin
		int          goal;
		int          pick;
		int          kind;
		logic [15:0] v;

		items_if.valid   = 1'b0;
		items_if.data    = '0;
		results_if.ready = 1'b0;
		cfg_if.valid     = 1'b0;
		cfg_if.data      = '0;
		arst_n           = 1'b0;
		errors           = 0;
		cycles           = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: reset period, request while busy, line low at idle
		push_item(LINE_IDLE, 1'b1, 8'hFF);
		repeat (3) push_item(LINE_IDLE, 1'b1, 8'h00);
		repeat (3) push_item(LINE_START, 1'b0, 8'h00);
		// widest period, then shortest, both with frames under way
		set_period(16'hFFFF);
		repeat (10) push_item(LINE_START, 1'b0, 8'h00);
		set_period(16'd2);
		tx_odds = 1000;
		push_frame(8'h00, 1'b0, 10);
		push_frame(8'hFF, 1'b1, 10);
		push_frame(8'hA5, 1'b0, 10);
		// request held high across the end of a frame
		repeat (22) push_item(LINE_IDLE, 1'b1, 8'h5A);
		// periods below the minimum
		set_period(16'd0);
		push_item(LINE_IDLE, 1'b1, 8'h3C);
		push_frame(8'h3C, 1'b0, 10);
		set_period(16'd1);
		push_item(LINE_IDLE, 1'b1, 8'hC3);
		push_frame(8'hC3, 1'b0, 10);
		// one whole frame at the reset period, with no idling
		set_period(PERIOD_RESET);
		steady = 1'b1;
		push_item(LINE_IDLE, 1'b1, 8'h7E);
		push_frame(8'h81, 1'b0, 10);
		repeat (60) push_tick(LINE_IDLE);
		wait_idle();
		steady = 1'b0;

		// Random: mostly clean frames at short periods, some noise
		goal = ticks_queued + 500;
		while (ticks_queued < goal) begin
			pick = $urandom_range(0, 9);
			if (pick < 6)
				v = 16'($urandom_range(2, 4));
			else if (pick < 7)
				v = 16'($urandom_range(0, 1));
			else
				v = 16'($urandom_range(5, 12));
			set_period(v);
			steady  = ($urandom_range(0, 3) == 0);
			tx_odds = $urandom_range(2, 12);
			repeat ($urandom_range(2, 5)) begin
				kind = $urandom_range(0, 9);
				if (kind < 7)
					push_frame(8'($urandom), $urandom_range(0, 7) == 0, 10);
				else if (kind < 9)
					push_frame(8'($urandom), 1'b0, $urandom_range(1, 9));
				else
					repeat ($urandom_range(1, 3 * line_ticks()))
						push_tick(1'($urandom_range(0, 1)));
				repeat ($urandom_range(0, 2 * line_ticks())) push_tick(LINE_IDLE);
			end
		end

		// Drain and settle
		wait_idle();
		repeat (8) @(posedge clk);
		if (due_status.size() != 0) begin
			$error("%0d status items never arrived", due_status.size());
			errors++;
		end
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/core/uart8_pkg.sv
rtl/core/uart8_chan_if.sv
rtl/core/uart8_tx.sv
rtl/core/uart8_rx.sv
rtl/core/uart_8n1_transceiver_core.sv
tb/sv/tb_top.sv
